/* src/mrc_pkg.sv */
// mrc_pkg: shared types and constants of the mixed-radix counter.
// Used by mrc_cell and mixed_radix_counter; no dependencies.
`timescale 1ns / 1ps

package mrc_pkg;

    localparam int VAL_W       = 64;
    localparam int POS_W       = 4;
    localparam int OP_W        = 2;
    localparam int CNT_W       = 7;
    localparam int CFG_ADDR_W  = 2;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 200;
    localparam int LOAD_BITS   = 64;

    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_INC  = 2'd1;
    localparam logic [OP_W-1:0] OP_COMP = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_DIGIT_BASES = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DIGITS_USED = 2'd1;

    localparam logic [VAL_W-1:0] BASES_RESET = 64'h0202_0202_0202_0202;
    localparam logic [POS_W-1:0] USED_RESET  = 4'd8;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic             settle;     // weight chain runs
        logic             clear_all;  // config write
        logic             load_init;  // clear remainders before a load
        logic             tok_start;  // inject carry at pos
        logic             comp_clr;   // clear digits below pos
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] used;
    } cell_cmd_t;

    typedef struct packed {
        logic absorb;
        logic pass;
    } cell_stat_t;

endpackage

/* src/mrc_cell.sv */
// mrc_cell: one digit of the counter: digit, place weight, carry token,
// bit-serial divider stage and a partial-sum stage. Depends on mrc_pkg.
`timescale 1ns / 1ps

module mrc_cell #(
    parameter int IDX        = 0,
    parameter int DIGIT_BITS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mrc_pkg::cell_cmd_t     cmd,
    input  logic [DIGIT_BITS-1:0]  base,
    input  logic [63:0]            w_in,
    output logic [63:0]            w_out,
    output logic [63:0]            w_q,
    input  logic                   tok_in,
    output mrc_pkg::cell_stat_t    stat,
    input  logic                   bit_in,
    input  logic                   bit_vld_in,
    output logic                   bit_out,
    output logic                   bit_vld_out,
    input  logic [63:0]            acc_in,
    output logic [63:0]            acc_out,
    output logic [DIGIT_BITS-1:0]  digit
);
    import mrc_pkg::*;

    localparam logic [POS_W-1:0] ID = POS_W'(IDX);

    logic [DIGIT_BITS-1:0]       digit_reg, digit_next;
    logic                        tok_reg, tok_next;
    logic                        bq_reg, bv_reg;
    logic [VAL_W-1:0]            w_reg, prod_reg, acc_reg;
    logic                        active, below;
    logic [DIGIT_BITS:0]         trial, rem, inc_v, base_x;
    logic                        ge, fits;
    logic [DIGIT_BITS-1:0]       m_op;
    logic [VAL_W+DIGIT_BITS-1:0] full;

    assign active = ID < cmd.used;
    assign below  = ID < cmd.pos;
    assign base_x = {1'b0, base};

    // restoring division, one dividend bit per cycle
    assign trial = {digit_reg, bit_in};
    assign ge    = trial >= base_x;
    assign rem   = ge ? trial - base_x : trial;

    assign inc_v = {1'b0, digit_reg} + {{DIGIT_BITS{1'b0}}, 1'b1};
    assign fits  = inc_v < base_x;

    assign stat.absorb = tok_reg && fits;
    assign stat.pass   = tok_reg && !fits;

    assign m_op = cmd.settle ? base : digit_reg;
    assign full = w_reg * m_op;

    always_comb
    begin
        digit_next = digit_reg;
        if (cmd.clear_all)
        begin
            digit_next = '0;
        end
        else if (cmd.load_init && active)
        begin
            digit_next = '0;
        end
        else if (bit_vld_in && active)
        begin
            digit_next = rem[DIGIT_BITS-1:0];
        end
        else if (cmd.comp_clr && below)
        begin
            digit_next = '0;
        end
        else if (tok_reg)
        begin
            digit_next = fits ? inc_v[DIGIT_BITS-1:0] : '0;
        end

        if (cmd.tok_start)
        begin
            tok_next = (ID == cmd.pos) && active;
        end
        else
        begin
            tok_next = tok_in && active;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
            tok_reg   <= 1'b0;
            bv_reg    <= 1'b0;
        end
        else
        begin
            digit_reg <= digit_next;
            tok_reg   <= tok_next;
            bv_reg    <= bit_vld_in && active;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.settle)
        begin
            w_reg <= w_in;
        end
        prod_reg <= full[VAL_W-1:0];
        acc_reg  <= acc_in + (below ? prod_reg : '0);
        bq_reg   <= ge;
    end

    assign w_out       = prod_reg;
    assign w_q         = w_reg;
    assign bit_out     = bq_reg;
    assign bit_vld_out = bv_reg;
    assign acc_out     = acc_reg;
    assign digit       = digit_reg;

endmodule

/* src/mixed_radix_counter.sv */
// mixed_radix_counter: top level, sequencer and a row of mrc_cell digits.
// Depends on mrc_pkg and mrc_cell.
`timescale 1ns / 1ps
//
//  port group    dir   contents
//  s_axis_*      in    command: operation, position, load_value
//  m_axis_*      out   result: value, digits, carry stop, wrap, total
//  cfg_*         in    register writes, no read-back
//
//  Increment: the carry token ripples up from the position until a digit absorbs it.
//  Complement: as increment, then the weighted-sum chain runs.
//  Load: load_value is fed bit-serially through the divider row.
//  After reset or a register write the weight chain settles
//  with s_axis_tready low.
//  A held result does not block the next command; only a finished one waits.

module mixed_radix_counter #(
    parameter int MAX_DIGITS = 8,
    parameter int DIGIT_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [1:0] operation, [5:2] position, [69:6] load_value, [71:70] zero
    input  logic [mrc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [63:0] linear_value, [127:64] digit_word, [131:128] carry_stop,
    // [132] wrapped, [196:133] total_count, [199:197] zero
    output logic [mrc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                cfg_we,
    input  logic [mrc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [mrc_pkg::VAL_W-1:0]           cfg_wdata
);
    import mrc_pkg::*;

    localparam int PACK_W = MAX_DIGITS * DIGIT_BITS;
    localparam int PAD_W  = (PACK_W > VAL_W) ? PACK_W : VAL_W;
    localparam logic [CNT_W-1:0] SETTLE_LAST = CNT_W'(2 * MAX_DIGITS + 2);
    localparam logic [CNT_W-1:0] SUM_LAST    = CNT_W'(MAX_DIGITS + 2);
    localparam logic [CNT_W-1:0] FEED_END    = CNT_W'(LOAD_BITS);

    typedef enum logic [2:0] {
        ST_SETTLE,
        ST_IDLE,
        ST_LOAD,
        ST_RIPPLE,
        ST_SUM,
        ST_DONE
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [VAL_W-1:0]         bases_reg, bases_next;
    logic [POS_W-1:0]         nused_reg, nused_next;
    logic [VAL_W-1:0]         value_reg, value_next;
    logic [OP_W-1:0]          op_reg, op_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [POS_W-1:0]         k_reg, k_next;
    logic [POS_W-1:0]         stop_reg, stop_next;
    logic                     wrap_reg, wrap_next;
    logic [VAL_W-1:0]         total_reg, total_next;
    logic [LOAD_BITS-1:0]     lv_reg, lv_next;
    logic                     out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0]   out_data_reg, out_data_next;

    cell_cmd_t                cmd;
    cell_stat_t               stat [MAX_DIGITS];
    logic [VAL_W-1:0]         w_prod [MAX_DIGITS];
    logic [VAL_W-1:0]         w_held [MAX_DIGITS];
    logic [VAL_W-1:0]         acc_chain [MAX_DIGITS];
    logic                     bq [MAX_DIGITS];
    logic                     bv [MAX_DIGITS];
    logic [DIGIT_BITS-1:0]    dig [MAX_DIGITS];
    logic [DIGIT_BITS-1:0]    base_f [MAX_DIGITS];

    logic [PAD_W-1:0]         bpad, dpack;
    logic [DIGIT_BITS-1:0]    bfield;
    logic [POS_W-1:0]         used, pos_c, in_pos;
    logic [OP_W-1:0]          in_op;
    logic [LOAD_BITS-1:0]     in_lv;
    logic                     in_fire, cfg_wr, out_free, load_feed;
    logic                     any_abs;
    logic [VAL_W-1:0]         w_pick, tot_pick, word;

    assign in_op  = s_axis_tdata[1:0];
    assign in_pos = s_axis_tdata[5:2];
    assign in_lv  = s_axis_tdata[69:6];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_wr        = cfg_we &&
                           (cfg_addr == REG_DIGIT_BASES || cfg_addr == REG_DIGITS_USED);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign load_feed     = (state_reg == ST_LOAD) && (cnt_reg < FEED_END);

    always_comb
    begin
        if (nused_reg == '0)
        begin
            used = POS_W'(1);
        end
        else if ({1'b0, nused_reg} > (POS_W + 1)'(MAX_DIGITS))
        begin
            used = POS_W'(MAX_DIGITS);
        end
        else
        begin
            used = nused_reg;
        end
        pos_c = (in_pos > used) ? used : in_pos;
    end

    always_comb
    begin
        bpad  = PAD_W'(bases_reg);
        dpack = '0;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            bfield    = bpad[i*DIGIT_BITS +: DIGIT_BITS];
            base_f[i] = (bfield == '0) ? DIGIT_BITS'(1) : bfield;
            dpack[i*DIGIT_BITS +: DIGIT_BITS] = dig[i];
        end
        word = dpack[VAL_W-1:0];
    end

    // weight of a position; at pos == used this equals the total count
    always_comb
    begin
        w_pick   = total_reg;
        tot_pick = w_prod[MAX_DIGITS-1];
        any_abs  = 1'b0;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (pos_c == POS_W'(i))
            begin
                w_pick = w_held[i];
            end
            if (used == POS_W'(i))
            begin
                tot_pick = w_held[i];
            end
            any_abs = any_abs | stat[i].absorb;
        end
    end

    for (genvar g = 0; g < MAX_DIGITS; g++)
    begin : g_cell
        logic             tin, bin, bvin;
        logic [VAL_W-1:0] win, ain;

        if (g == 0)
        begin : g_first
            assign tin  = 1'b0;
            assign bin  = lv_reg[LOAD_BITS-1];
            assign bvin = load_feed;
            assign win  = VAL_W'(1);
            assign ain  = '0;
        end
        else
        begin : g_next
            assign tin  = stat[g-1].pass;
            assign bin  = bq[g-1];
            assign bvin = bv[g-1];
            assign win  = w_prod[g-1];
            assign ain  = acc_chain[g-1];
        end

        mrc_cell #(
            .IDX        (g),
            .DIGIT_BITS (DIGIT_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .base        (base_f[g]),
            .w_in        (win),
            .w_out       (w_prod[g]),
            .w_q         (w_held[g]),
            .tok_in      (tin),
            .stat        (stat[g]),
            .bit_in      (bin),
            .bit_vld_in  (bvin),
            .bit_out     (bq[g]),
            .bit_vld_out (bv[g]),
            .acc_in      (ain),
            .acc_out     (acc_chain[g]),
            .digit       (dig[g])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg + CNT_W'(1);
        bases_next     = bases_reg;
        nused_next     = nused_reg;
        value_next     = value_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        k_next         = k_reg;
        stop_next      = stop_reg;
        wrap_next      = wrap_reg;
        total_next     = total_reg;
        lv_next        = lv_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;

        cmd            = '0;
        cmd.used       = used;
        cmd.pos        = (state_reg == ST_IDLE) ? pos_c : pos_reg;

        case (state_reg)
            ST_SETTLE:
            begin
                cmd.settle = 1'b1;
                if (cnt_reg == SETTLE_LAST)
                begin
                    total_next = tot_pick;
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_fire)
                begin
                    op_next   = in_op;
                    pos_next  = pos_c;
                    lv_next   = in_lv;
                    k_next    = pos_c;
                    stop_next = '0;
                    wrap_next = 1'b0;
                    cnt_next  = '0;
                    case (in_op)
                        OP_LOAD:
                        begin
                            value_next    = in_lv;
                            cmd.load_init = 1'b1;
                            state_next    = ST_LOAD;
                        end
                        OP_INC, OP_COMP:
                        begin
                            value_next    = value_reg + w_pick;
                            cmd.tok_start = 1'b1;
                            if (pos_c == used)
                            begin
                                stop_next  = used;
                                state_next = (in_op == OP_COMP) ? ST_SUM : ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_RIPPLE;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_LOAD:
            begin
                lv_next = {lv_reg[LOAD_BITS-2:0], 1'b0};
                if (cnt_reg == CNT_W'(LOAD_BITS - 1) + CNT_W'(used))
                begin
                    state_next = ST_DONE;
                end
            end

            ST_RIPPLE:
            begin
                cnt_next = '0;
                if (any_abs || (k_reg + POS_W'(1)) == used)
                begin
                    stop_next  = any_abs ? k_reg : used;
                    wrap_next  = !any_abs;
                    state_next = (op_reg == OP_COMP) ? ST_SUM : ST_DONE;
                end
                else
                begin
                    k_next = k_reg + POS_W'(1);
                end
            end

            ST_SUM:
            begin
                if (cnt_reg == SUM_LAST)
                begin
                    value_next   = value_reg - acc_chain[MAX_DIGITS-1];
                    cmd.comp_clr = 1'b1;
                    state_next   = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {3'b000, total_reg, wrap_reg, stop_reg, word, value_reg};
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_SETTLE;
                cnt_next   = '0;
            end
        endcase

        if (cfg_wr)
        begin
            if (cfg_addr == REG_DIGIT_BASES)
            begin
                bases_next = cfg_wdata;
            end
            else
            begin
                nused_next = cfg_wdata[POS_W-1:0];
            end
            value_next    = '0;
            cmd.clear_all = 1'b1;
            cmd.tok_start = 1'b0;
            cmd.load_init = 1'b0;
            cmd.comp_clr  = 1'b0;
            state_next    = ST_SETTLE;
            cnt_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SETTLE;
            cnt_reg       <= '0;
            bases_reg     <= BASES_RESET;
            nused_reg     <= USED_RESET;
            value_reg     <= '0;
            op_reg        <= OP_LOAD;
            pos_reg       <= '0;
            k_reg         <= '0;
            stop_reg      <= '0;
            wrap_reg      <= 1'b0;
            total_reg     <= '0;
            lv_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            bases_reg     <= bases_next;
            nused_reg     <= nused_next;
            value_reg     <= value_next;
            op_reg        <= op_next;
            pos_reg       <= pos_next;
            k_reg         <= k_next;
            stop_reg      <= stop_next;
            wrap_reg      <= wrap_next;
            total_reg     <= total_next;
            lv_reg        <= lv_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
